// File: rtl/utterance_chunk_planner_assert.svh
// Assertion macros used by the checker of the chunk planner.
`ifndef UTTERANCE_CHUNK_PLANNER_ASSERT_SVH
`define UTTERANCE_CHUNK_PLANNER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define UCP_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("chunk planner: same-cycle check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define UCP_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("chunk planner: next-cycle check failed");

`endif

// File: rtl/ucp_pkg.sv
package ucp_pkg;

    localparam int MAX_CHUNKS_DEF = 64;
    localparam int FRAME_BITS_DEF = 16;
    localparam int CFG_W          = 12;
    localparam int IDX_W          = 2;

    localparam logic [CFG_W-1:0] CHUNK_SIZE_RST    = 12'd150;
    localparam logic [CFG_W-1:0] TOTAL_CONTEXT_RST = 12'd0;
    localparam logic             PAD_INPUT_RST     = 1'b1;

    typedef enum logic [IDX_W-1:0] {
        REG_CHUNK_SIZE    = 2'd0,
        REG_TOTAL_CONTEXT = 2'd1,
        REG_PAD_INPUT     = 2'd2
    } cfg_index_t;

    typedef enum logic [1:0] {
        ST_CHUNK    = 2'd0,
        ST_SHORT    = 2'd1,
        ST_TOO_MANY = 2'd2,
        ST_CONTEXT  = 2'd3
    } status_t;

    typedef struct packed {
        logic    load;
        logic    div_start;
        logic    div_sel;
        logic    prep;
        logic    mul_a;
        logic    mul_b;
        logic    decide;
        logic    setup;
        logic    emit;
        logic    single;
        status_t code;
    } ctrl_cmd_t;

    typedef struct packed {
        logic short_len;
        logic short_ok;
        logic ctx_bad;
        logic div_done;
        logic too_many;
        logic last_item;
    } ctrl_stat_t;

endpackage

// File: rtl/utterance_chunk_planner.sv
// channel  | handshake          | word
// ---------+--------------------+----------------------------------
// config   | wr_en              | wr_index, wr_data
// input    | start && !busy     | frame_count
// result   | strobe             | start_frame, last, status
//
// Short, context or overflow cases: one result word.
// Chunked utterance: the shared radix-2 divider is run twice per utterance.
// Chunk words come out on consecutive cycles, one per clock.
// rst_n clears control and loads the register defaults; no clearing pass.
// The receiver cannot stall: each word is shown for exactly one cycle.
module utterance_chunk_planner #(
    parameter int MAX_CHUNKS = ucp_pkg::MAX_CHUNKS_DEF,
    parameter int FRAME_BITS = ucp_pkg::FRAME_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [ucp_pkg::IDX_W-1:0]  wr_index,
    input  logic [ucp_pkg::CFG_W-1:0]  wr_data,
    input  logic                       start,
    output logic                       busy,
    input  logic [FRAME_BITS-1:0]      frame_count,
    output logic                       strobe,
    output logic [FRAME_BITS-1:0]      start_frame,
    output logic                       last,
    output logic [1:0]                 status
);

    ucp_pkg::ctrl_cmd_t  cmd;
    ucp_pkg::ctrl_stat_t stat;

    ucp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    ucp_dp #(
        .MAX_CHUNKS (MAX_CHUNKS),
        .FRAME_BITS (FRAME_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .wr_en       (wr_en),
        .wr_index    (wr_index),
        .wr_data     (wr_data),
        .frame_count (frame_count),
        .cmd         (cmd),
        .stat        (stat),
        .strobe      (strobe),
        .start_frame (start_frame),
        .last        (last),
        .status      (status)
    );

endmodule

// File: rtl/ucp_div.sv
module ucp_div #(
    parameter int W = ucp_pkg::FRAME_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder,
    output logic         done
);

    localparam int CNTW = $clog2(W + 1);

    logic [W-1:0]    quo_reg, rem_reg, dvs_reg;
    logic [CNTW-1:0] cnt_reg;
    logic            run_reg, done_reg;

    logic [W:0]   trial, diff;
    logic         fits;
    logic [W-1:0] rem_next, quo_next;

    // restoring division, one quotient bit per cycle, MSB first
    always_comb
    begin
        trial    = {rem_reg, quo_reg[W-1]};
        diff     = trial - {1'b0, dvs_reg};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? diff[W-1:0] : trial[W-1:0];
        quo_next = {quo_reg[W-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNTW'(W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNTW'(1);
                if (cnt_reg == CNTW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// File: rtl/ucp_ctrl.sv
module ucp_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  ucp_pkg::ctrl_stat_t    stat,
    output ucp_pkg::ctrl_cmd_t     cmd,
    output logic                   busy
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_CHECK  = 9'b000000010,
        S_DIV1   = 9'b000000100,
        S_PREP   = 9'b000001000,
        S_MUL_A  = 9'b000010000,
        S_MUL_B  = 9'b000100000,
        S_DECIDE = 9'b001000000,
        S_DIV2   = 9'b010000000,
        S_EMIT   = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.code   = ucp_pkg::ST_CHUNK;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                priority if (stat.short_len)
                begin
                    cmd.single = 1'b1;
                    cmd.code   = stat.short_ok ? ucp_pkg::ST_CHUNK : ucp_pkg::ST_SHORT;
                    state_next = S_IDLE;
                end
                else if (stat.ctx_bad)
                begin
                    cmd.single = 1'b1;
                    cmd.code   = ucp_pkg::ST_CONTEXT;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_DIV1;
                end
            end
            S_DIV1:
            begin
                if (stat.div_done)
                    state_next = S_PREP;
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = S_MUL_A;
            end
            S_MUL_A:
            begin
                cmd.mul_a  = 1'b1;
                state_next = S_MUL_B;
            end
            S_MUL_B:
            begin
                cmd.mul_b  = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE:
            begin
                if (stat.too_many)
                begin
                    cmd.single = 1'b1;
                    cmd.code   = ucp_pkg::ST_TOO_MANY;
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.decide    = 1'b1;
                    cmd.div_start = 1'b1;
                    cmd.div_sel   = 1'b1;
                    state_next    = S_DIV2;
                end
            end
            S_DIV2:
            begin
                if (stat.div_done)
                begin
                    cmd.setup  = 1'b1;
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit = 1'b1;
                if (stat.last_item)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);

endmodule

// File: rtl/ucp_dp.sv
module ucp_dp #(
    parameter int MAX_CHUNKS = ucp_pkg::MAX_CHUNKS_DEF,
    parameter int FRAME_BITS = ucp_pkg::FRAME_BITS_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [ucp_pkg::IDX_W-1:0]  wr_index,
    input  logic [ucp_pkg::CFG_W-1:0]  wr_data,
    input  logic [FRAME_BITS-1:0]      frame_count,
    input  ucp_pkg::ctrl_cmd_t         cmd,
    output ucp_pkg::ctrl_stat_t        stat,
    output logic                       strobe,
    output logic [FRAME_BITS-1:0]      start_frame,
    output logic                       last,
    output logic [1:0]                 status
);

    localparam int FB = FRAME_BITS;
    localparam int VW = (FRAME_BITS > ucp_pkg::CFG_W) ? FRAME_BITS : ucp_pkg::CFG_W;
    localparam int MW = FRAME_BITS + 2;
    localparam int PW = 2 * MW;
    localparam int CW = $clog2(MAX_CHUNKS + 2);

    logic [ucp_pkg::CFG_W-1:0] chunk_size_reg, total_context_reg;
    logic                      pad_input_reg;

    logic [FB-1:0]   nf_reg, mnf_reg, mcs_reg, n1_reg, rem_reg, nn_reg, f1_reg;
    logic [FB-1:0]   q2_reg, pos_reg;
    logic [FB:0]     f2_reg;
    logic [FB+1:0]   x_reg;
    logic [PW-1:0]   p_reg, sq_reg;
    logic            gaps_reg;
    logic [CW-1:0]   b_reg, cnt_reg, thr_reg, idx_reg;

    logic                 strobe_reg, last_reg;
    logic [FB-1:0]        sf_reg;
    ucp_pkg::status_t     status_reg;

    logic [VW-1:0]   nf_w, cs_w, tc_w;
    logic [FB-1:0]   mnf_c, mcs_c;
    logic [FB-1:0]   div_a, div_b, quo, rem_out;
    logic            div_done;
    logic [FB-1:0]   f1_c, nn_c, n1_inc, piece_c, pos_next;
    logic [FB:0]     f2_c;
    logic [FB+1:0]   x_c;
    logic [MW-1:0]   mul_a_op, mul_b_op;
    logic [PW-1:0]   prod;
    logic            gaps_c, too_many_c, last_c;
    logic [CW-1:0]   idx_next, k_c;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chunk_size_reg    <= ucp_pkg::CHUNK_SIZE_RST;
            total_context_reg <= ucp_pkg::TOTAL_CONTEXT_RST;
            pad_input_reg     <= ucp_pkg::PAD_INPUT_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                ucp_pkg::REG_CHUNK_SIZE:    chunk_size_reg    <= wr_data;
                ucp_pkg::REG_TOTAL_CONTEXT: total_context_reg <= wr_data;
                ucp_pkg::REG_PAD_INPUT:     pad_input_reg     <= wr_data[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        nf_w  = VW'(nf_reg);
        cs_w  = VW'(chunk_size_reg);
        tc_w  = VW'(total_context_reg);
        // only used on the long path, where both fit the frame width
        mnf_c = FB'(nf_w - tc_w);
        mcs_c = FB'(cs_w - tc_w);

        f1_c  = mnf_reg - rem_out;
        nn_c  = mcs_reg - rem_out;
        f2_c  = {1'b0, f1_c} + {1'b0, mcs_reg};
        // mm + 4*nn = mnf + 3*nn
        x_c   = {2'b00, mnf_reg} + {2'b00, nn_c} + {1'b0, nn_c, 1'b0};

        mul_a_op = cmd.mul_a ? MW'(f2_reg) : MW'(f1_reg);
        mul_b_op = cmd.mul_a ? MW'(f2_reg) : x_reg;
        prod     = PW'(mul_a_op) * PW'(mul_b_op);

        // gaps when f2^2 <= f1 * (mm + 4nn)
        gaps_c     = sq_reg <= p_reg;
        n1_inc     = n1_reg + FB'(1);
        too_many_c = gaps_c ? (n1_reg > FB'(MAX_CHUNKS)) : (n1_reg >= FB'(MAX_CHUNKS));

        div_a = cmd.div_sel ? (gaps_c ? rem_reg : nn_reg) : mnf_c;
        div_b = cmd.div_sel ? (gaps_c ? n1_inc : n1_reg) : mcs_c;

        // piece k of an even split is q + 1 once k reaches b - r
        idx_next = idx_reg + CW'(1);
        k_c      = gaps_reg ? idx_next : idx_reg;
        piece_c  = q2_reg + FB'(k_c >= thr_reg);
        pos_next = gaps_reg ? (pos_reg + mcs_reg + piece_c) : (pos_reg + mcs_reg - piece_c);
        last_c   = (idx_next == cnt_reg);

        stat.short_len = nf_w <= cs_w;
        stat.short_ok  = (nf_w == cs_w) || pad_input_reg;
        stat.ctx_bad   = total_context_reg >= chunk_size_reg;
        stat.div_done  = div_done;
        stat.too_many  = too_many_c;
        stat.last_item = last_c;
    end

    ucp_div #(
        .W (FB)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .quotient  (quo),
        .remainder (rem_out),
        .done      (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            nf_reg <= frame_count;
        if (cmd.div_start && !cmd.div_sel)
        begin
            mnf_reg <= mnf_c;
            mcs_reg <= mcs_c;
        end
        if (cmd.prep)
        begin
            n1_reg  <= quo;
            rem_reg <= rem_out;
            nn_reg  <= nn_c;
            f1_reg  <= f1_c;
            f2_reg  <= f2_c;
            x_reg   <= x_c;
        end
        if (cmd.mul_a)
            p_reg <= prod;
        if (cmd.mul_b)
        begin
            sq_reg <= p_reg;
            p_reg  <= prod;
        end
        if (cmd.decide)
        begin
            gaps_reg <= gaps_c;
            b_reg    <= CW'(gaps_c ? n1_inc : n1_reg);
            cnt_reg  <= CW'(gaps_c ? n1_reg : n1_inc);
        end
        if (cmd.setup)
        begin
            q2_reg  <= quo;
            thr_reg <= b_reg - CW'(rem_out);
            pos_reg <= gaps_reg ? quo : '0;
            idx_reg <= '0;
        end
        if (cmd.emit)
        begin
            pos_reg <= pos_next;
            idx_reg <= idx_next;
        end
    end

    // result word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            strobe_reg <= 1'b0;
        else
            strobe_reg <= cmd.single || cmd.emit;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.single)
        begin
            sf_reg     <= '0;
            last_reg   <= 1'b1;
            status_reg <= cmd.code;
        end
        else if (cmd.emit)
        begin
            sf_reg     <= pos_reg;
            last_reg   <= last_c;
            status_reg <= ucp_pkg::ST_CHUNK;
        end
    end

    assign strobe      = strobe_reg;
    assign start_frame = sf_reg;
    assign last        = last_reg;
    assign status      = status_reg;

endmodule

// File: rtl/ucp_checker.sv
`include "utterance_chunk_planner_assert.svh"

module ucp_checker #(
    parameter int FRAME_BITS = ucp_pkg::FRAME_BITS_DEF
) (
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  strobe,
    input logic [FRAME_BITS-1:0] start_frame,
    input logic                  last,
    input logic [1:0]            status
);

    // a status word is always a lone final word at frame 0
    `UCP_ASSERT_IMP(a_status_alone, strobe && (status != ucp_pkg::ST_CHUNK), last && (start_frame == '0))

    // nothing comes out the cycle after an utterance is taken in
    `UCP_ASSERT_NXT(a_quiet_after_start, start && !busy, !strobe)

    // chunk words of one utterance leave back to back
    `UCP_ASSERT_NXT(a_burst_contiguous, strobe && !last, strobe)

    // the final word is never followed directly by another
    `UCP_ASSERT_NXT(a_gap_after_last, strobe && last, !strobe)

endmodule

bind utterance_chunk_planner ucp_checker #(
    .FRAME_BITS (FRAME_BITS)
) u_ucp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .strobe      (strobe),
    .start_frame (start_frame),
    .last        (last),
    .status      (status)
);
